### hw/rtl/nrpd_pkg.sv
// Shared types and constants for the nibble run-length pixel decoder.
`timescale 1ns / 1ps

package nrpd_pkg;

	localparam int NIB_W    = 4;
	localparam int PIX_W    = 8;
	localparam int LEN_W    = 12;
	localparam int PAL_N    = 16;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 64;

	// register indexes, selected by paddr[3]
	localparam logic REG_PAL_LOW  = 1'b0;
	localparam logic REG_PAL_HIGH = 1'b1;

	typedef logic [PAL_N-1:0][PIX_W-1:0] palette_t;

	// count decode phase
	typedef enum logic [2:0] {
		PH_FIRST  = 3'd0,
		PH_EXT_HI = 3'd1,
		PH_EXT_LO = 3'd2,
		PH_LONG1  = 3'd3,
		PH_LONG2  = 3'd4,
		PH_LONG3  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	// record being decoded
	typedef enum logic [2:0] {
		KIND_REPEAT    = 3'd0,
		KIND_COLOR     = 3'd1,
		KIND_MULTI     = 3'd2,
		KIND_RUN_COUNT = 3'd3,
		KIND_RUN_PIX   = 3'd4
	} kind_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] pixel;
		logic [LEN_W-1:0] length;
	} result_t;

endpackage

### hw/rtl/nrpd_cfg.sv
// APB register file holding the 16-entry palette.
`timescale 1ns / 1ps

module nrpd_cfg import nrpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output palette_t          palette
);

	logic [CFG_DW-1:0] pal_low_q;
	logic [CFG_DW-1:0] pal_high_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_low_q  <= '0;
			pal_high_q <= '0;
		end else if (wr_en) begin
			if (paddr[3] == REG_PAL_HIGH) begin
				pal_high_q <= pwdata;
			end else begin
				pal_low_q <= pwdata;
			end
		end
	end

	assign prdata  = (paddr[3] == REG_PAL_HIGH) ? pal_high_q : pal_low_q;
	assign palette = palette_t'({pal_high_q, pal_low_q});

endmodule

### hw/rtl/nrpd_core.sv
// Count and record decoder: state registers and the per-nibble step.
`timescale 1ns / 1ps

module nrpd_core import nrpd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [NIB_W-1:0] nib,
	input  logic             last,
	input  palette_t         palette,
	output result_t          res
);

	phase_t           phase_q, phase_n;
	kind_t            kind_q, kind_n;
	logic [LEN_W-1:0] cnt_q, cnt_n;
	logic [LEN_W-1:0] rep_q, rep_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			kind_q  <= KIND_REPEAT;
			cnt_q   <= '0;
			rep_q   <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			kind_q  <= kind_n;
			cnt_q   <= cnt_n;
			rep_q   <= rep_n;
		end
	end

	always_comb begin
		logic do_rec;
		phase_n    = phase_q;
		kind_n     = kind_q;
		cnt_n      = cnt_q;
		rep_n      = rep_q;
		do_rec     = 1'b1;
		res.valid  = 1'b0;
		res.pixel  = palette[nib];
		res.length = cnt_q;

		if (phase_q < PH_DONE) begin
			unique case (phase_q)
				PH_FIRST: begin
					if (nib == '0) begin
						phase_n = PH_EXT_HI;
					end else begin
						cnt_n   = LEN_W'(nib);
						phase_n = PH_DONE;
					end
				end
				PH_EXT_HI: begin
					cnt_n   = LEN_W'(nib);
					phase_n = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					cnt_n   = {cnt_q[LEN_W-NIB_W-1:0], nib};
					phase_n = (cnt_n == '0) ? PH_LONG1 : PH_DONE;
				end
				PH_LONG1: begin
					cnt_n   = {cnt_q[LEN_W-NIB_W-1:0], nib};
					phase_n = PH_LONG2;
				end
				PH_LONG2: begin
					cnt_n   = {cnt_q[LEN_W-NIB_W-1:0], nib};
					phase_n = PH_LONG3;
				end
				PH_LONG3: begin
					cnt_n   = {cnt_q[LEN_W-NIB_W-1:0], nib};
					phase_n = PH_DONE;
				end
				default: begin
				end
			endcase
			do_rec = (phase_n == PH_DONE);
		end

		// record logic runs on the nibble that completes a count, too
		if (do_rec) begin
			unique case (kind_q)
				KIND_COLOR: begin
					if (cnt_n != '0) begin
						res.valid  = 1'b1;
						res.length = cnt_n;
					end
					if (rep_q == '0) begin
						kind_n = KIND_RUN_COUNT;
					end else begin
						rep_n  = rep_q - LEN_W'(1);
						kind_n = KIND_REPEAT;
					end
					phase_n = PH_FIRST;
				end
				KIND_MULTI: begin
					rep_n   = cnt_n - LEN_W'(1);
					kind_n  = KIND_REPEAT;
					phase_n = PH_FIRST;
				end
				KIND_RUN_COUNT: begin
					if (cnt_n == '0) begin
						kind_n  = KIND_REPEAT;
						phase_n = PH_FIRST;
					end else begin
						kind_n = KIND_RUN_PIX;
					end
				end
				KIND_RUN_PIX: begin
					res.valid  = 1'b1;
					res.length = LEN_W'(1);
					cnt_n      = cnt_n - LEN_W'(1);
					if (cnt_n == '0) begin
						kind_n  = KIND_REPEAT;
						phase_n = PH_FIRST;
					end
				end
				default: begin
					if (cnt_n == LEN_W'(1)) begin
						kind_n  = KIND_RUN_COUNT;
						phase_n = PH_FIRST;
					end else if (cnt_n == LEN_W'(2)) begin
						kind_n  = KIND_MULTI;
						phase_n = PH_FIRST;
					end else begin
						kind_n = KIND_COLOR;
					end
				end
			endcase
		end

		if (last) begin
			phase_n = PH_FIRST;
			kind_n  = KIND_REPEAT;
			cnt_n   = '0;
			rep_n   = '0;
		end
	end

endmodule

### hw/rtl/nibble_rle_pixel_decoder.sv
// Top level of the nibble run-length pixel decoder.
//
//   channel  signals                               direction
//   in       in_valid/in_ready, nibble_in,         beat in, one nibble
//            final_nibble
//   out      out_valid/out_ready, pixel_value,     beat out, zero or one per nibble
//            run_length
//   cfg      APB psel/penable/pwrite/paddr/pwdata  palette writes at 0x0 and 0x8
//
// One nibble per cycle sustained while the output is not stalled; a beat is
// held in the input register and its result is registered into the output
// register when the beat advances.
// arst_n clears decode state, pipeline valids and the palette.
// A stalled output holds the input register; one further beat is taken while
// a result waits.
`timescale 1ns / 1ps

module nibble_rle_pixel_decoder import nrpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [NIB_W-1:0]  nibble_in,
	input  logic              final_nibble,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  pixel_value,
	output logic [LEN_W-1:0]  run_length
);

	palette_t         palette;
	result_t          res;
	logic             valid_s1;
	logic [NIB_W-1:0] nibble_s1;
	logic             final_s1;
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_q;
	logic [LEN_W-1:0] length_q;
	logic             out_free;
	logic             advance;

	nrpd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.palette (palette)
	);

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			nibble_s1 <= nibble_in;
			final_s1  <= final_nibble;
		end
	end

	nrpd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.nib     (nibble_s1),
		.last    (final_s1),
		.palette (palette),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			pixel_q  <= res.pixel;
			length_q <= res.length;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_value = pixel_q;
	assign run_length  = length_q;

endmodule

### verif/testbench.sv
// Self-checking testbench for the nibble run-length pixel decoder.
`timescale 1ns / 1ps

module testbench import nrpd_pkg::*; ();

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [LEN_W-1:0] length;
	} pixel_run_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [NIB_W-1:0]  nibble_in;
	logic              final_nibble;
	logic              out_valid;
	logic              out_ready;
	logic [PIX_W-1:0]  pixel_value;
	logic [LEN_W-1:0]  run_length;

	// decoder shadow state
	palette_t         pal_shadow;
	phase_t           dec_phase;
	kind_t            dec_kind;
	logic [LEN_W-1:0] dec_count;
	logic [LEN_W-1:0] dec_repeats;

	pixel_run_t       pending_runs[$];
	logic [NIB_W-1:0] frame_nibs[$];
	int               mismatches;
	int               gap_pct;
	int               stall_pct;

	nibble_rle_pixel_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.nibble_in(nibble_in),
		.final_nibble(final_nibble),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_value(pixel_value),
		.run_length(run_length)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("nibble_rle_pixel_decoder regression: fail");
		$finish;
	end

	function automatic void clear_decoder();
		dec_phase   = PH_FIRST;
		dec_kind    = KIND_REPEAT;
		dec_count   = '0;
		dec_repeats = '0;
	endfunction

	function automatic bit decode_nibble(input logic [NIB_W-1:0] nib, output pixel_run_t run);
		bit emit;
		bit finish;
		emit   = 1'b0;
		finish = 1'b1;
		run    = '0;
		if (dec_phase != PH_DONE) begin
			case (dec_phase)
				PH_FIRST: begin
					if (nib == 0) begin
						dec_phase = PH_EXT_HI;
					end else begin
						dec_count = LEN_W'(nib);
						dec_phase = PH_DONE;
					end
				end
				PH_EXT_HI: begin
					dec_count = LEN_W'(nib);
					dec_phase = PH_EXT_LO;
				end
				PH_EXT_LO: begin
					dec_count = {dec_count[7:0], nib};
					dec_phase = (dec_count == 0) ? PH_LONG1 : PH_DONE;
				end
				default: begin
					dec_count = {dec_count[7:0], nib};
					dec_phase = phase_t'(dec_phase + 3'd1);
				end
			endcase
			if (dec_phase != PH_DONE)
				return 1'b0;
		end
		case (dec_kind)
			KIND_COLOR: begin
				if (dec_count != 0) begin
					run.pixel  = pal_shadow[nib];
					run.length = dec_count;
					emit = 1'b1;
				end
				if (dec_repeats == 0) begin
					dec_kind = KIND_RUN_COUNT;
				end else begin
					dec_repeats = dec_repeats - 12'd1;
					dec_kind    = KIND_REPEAT;
				end
			end
			KIND_MULTI: begin
				dec_repeats = dec_count - 12'd1;
				dec_kind    = KIND_REPEAT;
			end
			KIND_RUN_COUNT: begin
				if (dec_count == 0) begin
					dec_kind = KIND_REPEAT;
				end else begin
					dec_kind = KIND_RUN_PIX;
					finish   = 1'b0;
				end
			end
			KIND_RUN_PIX: begin
				run.pixel  = pal_shadow[nib];
				run.length = 12'd1;
				emit = 1'b1;
				dec_count = dec_count - 12'd1;
				if (dec_count != 0)
					finish = 1'b0;
				else
					dec_kind = KIND_REPEAT;
			end
			default: begin
				if (dec_count == 1) begin
					dec_kind = KIND_RUN_COUNT;
				end else if (dec_count == 2) begin
					dec_kind = KIND_MULTI;
				end else begin
					dec_kind = KIND_COLOR;
					finish   = 1'b0;
				end
			end
		endcase
		if (finish)
			dec_phase = PH_FIRST;
		return emit;
	endfunction

	// output side: random backpressure bursts
	initial begin
		out_ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pixel_run_t exp_run;
		if (arst_n && out_valid && out_ready) begin
			if (pending_runs.size() == 0) begin
				$display("%0t: unexpected beat, pixel_value %0h run_length %0d", $time,
					pixel_value, run_length);
				mismatches++;
			end else begin
				exp_run = pending_runs.pop_front();
				if (pixel_value !== exp_run.pixel) begin
					$display("%0t: pixel_value expected %0h got %0h", $time,
						exp_run.pixel, pixel_value);
					mismatches++;
				end
				if (run_length !== exp_run.length) begin
					$display("%0t: run_length expected %0d got %0d", $time,
						exp_run.length, run_length);
					mismatches++;
				end
			end
		end
	end

	task automatic send_nibble(input logic [NIB_W-1:0] nib, input bit last);
		pixel_run_t run;
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		nibble_in    <= nib;
		final_nibble <= last;
		do @(posedge clk); while (!in_ready);
		if (decode_nibble(nib, run))
			pending_runs.push_back(run);
		if (last)
			clear_decoder();
	endtask

	task automatic send_frame(input bit mark_final);
		for (int i = 0; i < frame_nibs.size(); i++)
			send_nibble(frame_nibs[i], mark_final && (i == frame_nibs.size() - 1));
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_runs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_cycle(input bit wr, input logic sel, input logic [CFG_DW-1:0] wdata,
			output logic [CFG_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 3'b000};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_palette_reg(input logic sel, input logic [CFG_DW-1:0] want);
		logic [CFG_DW-1:0] got;
		apb_cycle(1'b0, sel, '0, got);
		if (got !== want) begin
			$display("%0t: prdata at %0h expected %0h got %0h", $time, {sel, 3'b000},
				want, got);
			mismatches++;
		end
	endtask

	task automatic write_palette(input logic sel, input logic [CFG_DW-1:0] value);
		logic [CFG_DW-1:0] unused;
		apb_cycle(1'b1, sel, value, unused);
		if (sel == REG_PAL_LOW)
			pal_shadow[7:0] = value;
		else
			pal_shadow[15:8] = value;
		check_palette_reg(sel, value);
	endtask

	task automatic set_palette(input logic [CFG_DW-1:0] lo, input logic [CFG_DW-1:0] hi);
		settle();
		write_palette(REG_PAL_LOW, lo);
		write_palette(REG_PAL_HIGH, hi);
	endtask

	function automatic void put_count(input logic [LEN_W-1:0] v);
		int unsigned form;
		form = $urandom_range(0, 2);
		if (v >= 1 && v <= 15 && form == 0) begin
			frame_nibs.push_back(v[3:0]);
		end else if (v >= 1 && v <= 255 && form != 2) begin
			frame_nibs.push_back(4'h0);
			frame_nibs.push_back(v[7:4]);
			frame_nibs.push_back(v[3:0]);
		end else begin
			frame_nibs.push_back(4'h0);
			frame_nibs.push_back(4'h0);
			frame_nibs.push_back(4'h0);
			frame_nibs.push_back(v[11:8]);
			frame_nibs.push_back(v[7:4]);
			frame_nibs.push_back(v[3:0]);
		end
	endfunction

	function automatic void put_repeat();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			put_count(12'd0);
		else if (sel == 1)
			put_count(LEN_W'($urandom_range(3, 4095)));
		else
			put_count(LEN_W'($urandom_range(3, 20)));
		frame_nibs.push_back(NIB_W'($urandom));
	endfunction

	function automatic void put_record_pair();
		int unsigned sel;
		int unsigned reps;
		int unsigned pixels;
		sel = $urandom_range(0, 5);
		if (sel == 0) begin
			put_count(12'd1);
		end else if (sel == 1) begin
			reps = $urandom_range(1, 4);
			put_count(12'd2);
			put_count(LEN_W'(reps));
			repeat (reps) put_repeat();
		end else begin
			put_repeat();
		end
		pixels = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		put_count(LEN_W'(pixels));
		repeat (pixels) frame_nibs.push_back(NIB_W'($urandom));
	endfunction

	// mostly well-formed images, some cut short (with or without final), some noise
	task automatic run_random(input int target);
		int sent;
		int pick;
		int cut;
		sent = 0;
		while (sent < target) begin
			frame_nibs.delete();
			pick = $urandom_range(0, 9);
			if (pick == 9) begin
				repeat ($urandom_range(1, 30)) frame_nibs.push_back(NIB_W'($urandom));
				send_frame(1'b1);
			end else begin
				repeat ($urandom_range(1, 6)) put_record_pair();
				if (pick >= 7) begin
					cut = $urandom_range(1, frame_nibs.size());
					while (frame_nibs.size() > cut) void'(frame_nibs.pop_back());
					send_frame(pick == 7);
				end else begin
					send_frame(1'b1);
				end
			end
			sent += frame_nibs.size();
		end
	endtask

	task automatic test_palette_regs();
		check_palette_reg(REG_PAL_LOW, '0);
		check_palette_reg(REG_PAL_HIGH, '0);
		set_palette(64'h7766554433221100, 64'hFFEEDDCCBBAA9988);
	endtask

	// short, 8-bit and 12-bit counts; longest repeat; empty literal run
	task automatic test_count_forms();
		gap_pct   = 20;
		stall_pct = 20;
		frame_nibs = '{4'hF, 4'h0,
			4'h0, 4'h0, 4'h3, 4'hF, 4'h8, 4'h7,
			4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'h9,
			4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0};
		send_frame(1'b1);
	endtask

	// skipped repeat, zero repeat length, zero multi-repeat count
	task automatic test_special_records();
		frame_nibs = '{4'h1, 4'h1, 4'h3,
			4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h5,
			4'h1, 4'hE,
			4'h2, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0,
			4'h7, 4'hC};
		send_frame(1'b1);
	endtask

	task automatic test_random_phases();
		set_palette('1, '1);
		gap_pct   = 15;
		stall_pct = 15;
		run_random(160);
		set_palette('0, '0);
		gap_pct   = 40;
		stall_pct = 40;
		run_random(160);
		set_palette({$urandom, $urandom}, {$urandom, $urandom});
		gap_pct   = 0;
		stall_pct = 30;
		run_random(160);
		set_palette(64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
		gap_pct   = 30;
		stall_pct = 0;
		run_random(160);
		set_palette({$urandom, $urandom}, {$urandom, $urandom});
		gap_pct   = 0;
		stall_pct = 0;
		run_random(160);
	endtask

	initial begin
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		nibble_in    = '0;
		final_nibble = 1'b0;
		gap_pct      = 0;
		stall_pct    = 0;
		mismatches   = 0;
		pal_shadow   = '0;
		clear_decoder();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_palette_regs();
		test_count_forms();
		test_special_records();
		test_random_phases();
		settle();
		if (mismatches == 0)
			$display("nibble_rle_pixel_decoder regression: pass");
		else
			$display("nibble_rle_pixel_decoder regression: fail");
		$finish;
	end

endmodule

### nibble_rle_pixel_decoder.f
hw/rtl/nrpd_pkg.sv
hw/rtl/nrpd_cfg.sv
hw/rtl/nrpd_core.sv
hw/rtl/nibble_rle_pixel_decoder.sv
verif/testbench.sv
